// ===== sv/twi_pkg.sv =====
// Shared types and codes for the two-wire master/slave sequencer.
`default_nettype none
package twi_pkg;

  // Command codes carried by an input beat.
  typedef enum logic [2:0] {
    CMD_BUS_EVENT = 3'd0,
    CMD_WRITE_BUF = 3'd1,
    CMD_START_MST = 3'd2,
    CMD_SLV_LISTEN = 3'd3,
    CMD_SLV_RESPOND = 3'd4,
    CMD_READ_BUF = 3'd5,
    CMD_RSVD6 = 3'd6,
    CMD_RSVD7 = 3'd7
  } cmd_e;

  // Buffer selectors.
  localparam logic [1:0] BUF_MTX = 2'd0;
  localparam logic [1:0] BUF_MRX = 2'd1;
  localparam logic [1:0] BUF_SRX = 2'd2;
  localparam logic [1:0] BUF_STX = 2'd3;

  // Bus status codes (status register bits 7:3).
  localparam logic [4:0] ST_BUS_ERR = 5'h00;
  localparam logic [4:0] ST_START = 5'h01;
  localparam logic [4:0] ST_RSTART = 5'h02;
  localparam logic [4:0] ST_MT_SLA_ACK = 5'h03;
  localparam logic [4:0] ST_MT_SLA_NACK = 5'h04;
  localparam logic [4:0] ST_MT_DAT_ACK = 5'h05;
  localparam logic [4:0] ST_MT_DAT_NACK = 5'h06;
  localparam logic [4:0] ST_ARB_LOST = 5'h07;
  localparam logic [4:0] ST_MR_SLA_ACK = 5'h08;
  localparam logic [4:0] ST_MR_SLA_NACK = 5'h09;
  localparam logic [4:0] ST_MR_DAT_ACK = 5'h0A;
  localparam logic [4:0] ST_MR_DAT_NACK = 5'h0B;
  localparam logic [4:0] ST_SR_SLA = 5'h0C;
  localparam logic [4:0] ST_SR_SLA_ARB = 5'h0D;
  localparam logic [4:0] ST_SR_GCA = 5'h0E;
  localparam logic [4:0] ST_SR_GCA_ARB = 5'h0F;
  localparam logic [4:0] ST_SR_DAT_ACK = 5'h10;
  localparam logic [4:0] ST_SR_DAT_NACK = 5'h11;
  localparam logic [4:0] ST_SR_GDAT_ACK = 5'h12;
  localparam logic [4:0] ST_SR_GDAT_NACK = 5'h13;
  localparam logic [4:0] ST_SR_STOP = 5'h14;
  localparam logic [4:0] ST_ST_SLA = 5'h15;
  localparam logic [4:0] ST_ST_SLA_ARB = 5'h16;
  localparam logic [4:0] ST_ST_DAT_ACK = 5'h17;
  localparam logic [4:0] ST_ST_DAT_NACK = 5'h18;
  localparam logic [4:0] ST_ST_LAST = 5'h19;
  localparam logic [4:0] ST_NO_INFO = 5'h1F;

  // Control register bits.
  localparam logic [7:0] C_INT = 8'h80;
  localparam logic [7:0] C_EA = 8'h40;
  localparam logic [7:0] C_STA = 8'h20;
  localparam logic [7:0] C_STO = 8'h10;
  localparam logic [7:0] C_EN = 8'h04;
  localparam logic [7:0] C_IE = 8'h01;
  localparam logic [7:0] C_GO = C_INT | C_EN | C_IE;

  // One unpacked input beat.
  typedef struct packed {
    logic [5:0] rx_length;
    logic [5:0] tx_length;
    logic [6:0] target_address;
    logic [7:0] value;
    logic [4:0] index;
    logic [1:0] buffer_select;
    logic [7:0] ctrl_now;
    logic [7:0] bus_data;
    logic [4:0] status;
    logic [2:0] command;
  } in_item_t;

  // Result of the decision stage, before the buffer read data is merged.
  typedef struct packed {
    logic       ctrl_write;
    logic [7:0] ctrl_value;
    logic       data_write;
    logic [7:0] data_const;
    logic       data_from_buf;
    logic       read_from_buf;
    logic       rd_in_range;
    logic [2:0] done_events;
    logic       busy;
    logic [1:0] master_error;
    logic       slave_error;
    logic [5:0] master_count;
    logic [5:0] slave_count;
    logic [7:0] address_seen;
  } core_res_t;

  function automatic logic [5:0] inc6(input logic [5:0] x);
    return (x != 6'd63) ? x + 6'd1 : 6'd63;
  endfunction

endpackage
`default_nettype wire

// ===== sv/twi_master_slave_sequencer.sv =====
// Top level of the two-wire master/slave sequencer: stream ports and pipeline.
//
// Channel   | Dir | Handshake                | Payload
// s_axis    | in  | s_axis_tvalid/tready     | command beat, 58 bits in 64
// m_axis    | out | m_axis_tvalid/tready     | result beat, 53 bits in 56
//
// One beat per cycle is sustained while m_axis_tready stays high; a result passes the
// input register, then the decision and buffer RAM read into the result register.
// The buffer RAM read is registered, which sets the second stage.
// Reset clears the sequencer state; buffers hold garbage until written.
// A stalled result holds the whole pipeline and drops s_axis_tready.
`default_nettype none
module twi_master_slave_sequencer import twi_pkg::*; #(
  parameter int BUFFER_DEPTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // command[2:0] status[7:3] bus_data[15:8] ctrl_now[23:16] buffer_select[25:24]
  // index[30:26] value[38:31] target_address[45:39] tx_length[51:46]
  // rx_length[57:52], zero above
  input  wire logic [63:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // ctrl_write[0] ctrl_value[8:1] data_write[9] data_value[17:10]
  // done_events[20:18] busy_res[21] master_error[23:22] slave_error[24]
  // read_value[32:25] master_count[38:33] slave_count[44:39]
  // slave_address_seen[52:45], zero above
  output logic [55:0]      m_axis_tdata
);

  localparam int AW = $clog2(4*BUFFER_DEPTH);

  logic      adv, s1_valid_q, out_valid_q;
  in_item_t  s1_item_q;
  core_res_t res, res_q;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic [7:0]    dv, rv;

  assign adv = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_valid_q;

  // Pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= s_axis_tvalid;
      out_valid_q <= s1_valid_q;
    end
  end

  // Input and result payload registers.
  always_ff @(posedge clk_i) begin
    if (adv && s_axis_tvalid) begin
      s1_item_q <= in_item_t'(s_axis_tdata[57:0]);
    end
    if (adv && s1_valid_q) begin
      res_q <= res;
    end
  end

  twi_core #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_core (
    .clk_i, .rst_ni,
    .en_i(adv && s1_valid_q),
    .item_i(s1_item_q),
    .res_o(res),
    .ram_we_o(ram_we), .ram_waddr_o(ram_waddr), .ram_wdata_o(ram_wdata),
    .ram_raddr_o(ram_raddr)
  );

  twi_ram #(.Width(8), .Depth(4*BUFFER_DEPTH)) u_buf (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .re_i(adv), .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  // Merge buffer read data into the result beat.
  always_comb begin
    dv = res_q.data_from_buf ? (res_q.rd_in_range ? ram_rdata : 8'h00)
                             : res_q.data_const;
    if (!res_q.data_write) dv = 8'h00;
    rv = (res_q.read_from_buf && res_q.rd_in_range) ? ram_rdata : 8'h00;
    m_axis_tdata = {3'b000, res_q.address_seen, res_q.slave_count,
                    res_q.master_count, rv, res_q.slave_error, res_q.master_error,
                    res_q.busy, res_q.done_events, dv, res_q.data_write,
                    res_q.ctrl_value, res_q.ctrl_write};
  end

endmodule
`default_nettype wire

// ===== sv/twi_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module twi_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== sv/twi_core.sv =====
// Decision logic and sequencer state for one registered beat.
`default_nettype none
module twi_core import twi_pkg::*; #(
  parameter int BUFFER_DEPTH = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                en_i,
  input  wire in_item_t                            item_i,
  output core_res_t                                res_o,
  output logic                                     ram_we_o,
  output logic [$clog2(4*BUFFER_DEPTH)-1:0]        ram_waddr_o,
  output logic [7:0]                               ram_wdata_o,
  output logic [$clog2(4*BUFFER_DEPTH)-1:0]        ram_raddr_o
);

  localparam int AW = $clog2(4*BUFFER_DEPTH);

  logic [7:0] sla_q, sla_d, adr_q, adr_d;
  logic [5:0] mtl_q, mtl_d, mti_q, mti_d, mrl_q, mrl_d, mri_q, mri_d;
  logic [5:0] srl_q, srl_d, sri_q, sri_d, stl_q, stl_d, sti_q, sti_d;
  logic       busy_q, busy_d, lis_q, lis_d, serr_q, serr_d;
  logic [1:0] merr_q, merr_d;

  // State registers, updated once per processed beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sla_q <= '0; adr_q <= '0;
      mtl_q <= '0; mti_q <= '0; mrl_q <= '0; mri_q <= '0;
      srl_q <= '0; sri_q <= '0; stl_q <= '0; sti_q <= '0;
      busy_q <= 1'b0; lis_q <= 1'b0; serr_q <= 1'b0; merr_q <= '0;
    end else if (en_i) begin
      sla_q <= sla_d; adr_q <= adr_d;
      mtl_q <= mtl_d; mti_q <= mti_d; mrl_q <= mrl_d; mri_q <= mri_d;
      srl_q <= srl_d; sri_q <= sri_d; stl_q <= stl_d; sti_q <= sti_d;
      busy_q <= busy_d; lis_q <= lis_d; serr_q <= serr_d; merr_q <= merr_d;
    end
  end

  // Next state and result for the registered beat.
  always_comb begin
    logic       cw, dw, dbuf, rbuf, nack, srnack, stdat, mrack, mpend, we;
    logic [7:0] cv, dc, wdata;
    logic [2:0] done;
    logic [1:0] wsel, rsel;
    logic [5:0] wpos, rpos, ti;
    cw = 1'b0; dw = 1'b0; dbuf = 1'b0; rbuf = 1'b0; we = 1'b0;
    nack = 1'b0; srnack = 1'b0; stdat = 1'b0; mrack = 1'b0;
    cv = '0; dc = '0; done = '0; wdata = item_i.bus_data;
    wsel = BUF_MRX; wpos = mri_q; rsel = BUF_MTX; rpos = mti_q; ti = sti_q;
    mpend = (mtl_q != '0) || (mrl_q != '0);
    sla_d = sla_q; adr_d = adr_q;
    mtl_d = mtl_q; mti_d = mti_q; mrl_d = mrl_q; mri_d = mri_q;
    srl_d = srl_q; sri_d = sri_q; stl_d = stl_q; sti_d = sti_q;
    busy_d = busy_q; lis_d = lis_q; serr_d = serr_q; merr_d = merr_q;

    case (cmd_e'(item_i.command))
      CMD_BUS_EVENT: begin
        case (item_i.status)
          ST_START, ST_RSTART: begin
            busy_d = 1'b1; mti_d = '0; mri_d = '0;
            dw = 1'b1; dc = (mtl_q != '0) ? sla_q : (sla_q | 8'h01);
            cw = 1'b1; cv = C_GO | (item_i.ctrl_now & C_EA);
          end
          ST_MT_SLA_ACK, ST_MT_DAT_ACK: begin
            if (mti_q < mtl_q) begin
              dw = 1'b1; dbuf = 1'b1; rsel = BUF_MTX; rpos = mti_q;
              mti_d = inc6(mti_q);
              cw = 1'b1; cv = C_GO | (item_i.ctrl_now & C_EA);
            end else begin
              mtl_d = '0;
              if (mrl_q != '0) begin
                cw = 1'b1; cv = C_GO | (item_i.ctrl_now & C_EA) | C_STA;
              end else begin
                nack = 1'b1;
              end
            end
          end
          ST_MT_SLA_NACK, ST_MT_DAT_NACK, ST_MR_SLA_NACK: nack = 1'b1;
          ST_ARB_LOST: begin
            cw = 1'b1; cv = item_i.ctrl_now | C_STA; busy_d = 1'b0;
          end
          ST_MR_DAT_ACK: begin
            we = 1'b1; wsel = BUF_MRX; wpos = mri_q;
            mri_d = inc6(mri_q); mrack = 1'b1;
          end
          ST_MR_SLA_ACK: mrack = 1'b1;
          ST_MR_DAT_NACK: begin
            we = 1'b1; wsel = BUF_MRX; wpos = mri_q;
            mri_d = inc6(mri_q); mrl_d = '0; done[0] = 1'b1;
            cw = 1'b1; cv = C_GO | C_STO | ((srl_q != '0) ? C_EA : 8'h00);
            busy_d = 1'b0;
          end
          ST_SR_SLA, ST_SR_SLA_ARB, ST_SR_GCA, ST_SR_GCA_ARB: begin
            cw = 1'b1;
            if (srl_q != '0) begin
              busy_d = 1'b1; adr_d = item_i.bus_data; cv = C_GO | C_EA; sri_d = '0;
            end else begin
              cv = C_GO;
            end
          end
          ST_SR_DAT_ACK, ST_SR_GDAT_ACK: begin
            if (sri_q < srl_q) begin
              we = 1'b1; wsel = BUF_SRX; wpos = sri_q; sri_d = inc6(sri_q);
            end else begin
              srl_d = '0;
            end
            if (srl_d != '0) begin
              cw = 1'b1; cv = C_GO | C_EA;
            end else begin
              srnack = 1'b1;
            end
          end
          ST_SR_DAT_NACK, ST_SR_GDAT_NACK: srnack = 1'b1;
          ST_SR_STOP: begin
            cw = 1'b1;
            if (!lis_q || serr_q) begin
              cv = C_GO | (mpend ? C_STA : 8'h00); busy_d = 1'b0;
            end else begin
              done[1] = 1'b1; lis_d = 1'b0; srl_d = '0;
              cv = item_i.ctrl_now & ~(C_INT | C_IE);
            end
          end
          ST_ST_SLA, ST_ST_SLA_ARB: begin
            busy_d = 1'b1; ti = '0; stdat = 1'b1;
          end
          ST_ST_DAT_ACK: stdat = 1'b1;
          ST_ST_DAT_NACK, ST_ST_LAST: begin
            done[2] = 1'b1; cw = 1'b1;
            cv = C_GO | C_EA | (mpend ? C_STA : 8'h00); busy_d = 1'b0;
          end
          ST_BUS_ERR: begin
            cw = 1'b1; cv = item_i.ctrl_now | C_STO; busy_d = 1'b0;
            merr_d = 2'd2; serr_d = 1'b1; lis_d = 1'b0; done = 3'b111;
          end
          default: ;
        endcase
        // Not-acknowledge paths end the master transfer with a stop.
        if (nack) begin
          if (item_i.status == ST_MT_SLA_NACK || item_i.status == ST_MR_SLA_NACK) begin
            merr_d = 2'd1; mtl_d = '0; mrl_d = '0;
          end
          done[0] = 1'b1;
          cw = 1'b1; cv = C_GO | C_STO | ((srl_q != '0) ? C_EA : 8'h00);
          busy_d = 1'b0;
        end
        // Master receive acknowledges until the last byte is due.
        if (mrack) begin
          cw = 1'b1;
          cv = ({1'b0, mri_d} + 7'd1 < {1'b0, mrl_q}) ? (C_GO | C_EA) : C_GO;
        end
        if (srnack) begin
          cw = 1'b1; cv = item_i.ctrl_now | C_EA | (mpend ? C_STA : 8'h00);
        end
        // Slave transmit sends a dummy zero byte once its data runs out.
        if (stdat) begin
          dw = 1'b1; cw = 1'b1; sti_d = ti;
          if (ti < stl_q) begin
            dbuf = 1'b1; rsel = BUF_STX; rpos = ti;
            sti_d = inc6(ti);
            if (inc6(ti) < stl_q) begin
              cv = C_GO | C_EA;
            end else begin
              stl_d = '0; cv = C_GO;
            end
          end else begin
            cv = C_GO;
          end
        end
      end
      CMD_WRITE_BUF: begin
        we = 1'b1; wsel = item_i.buffer_select; wpos = {1'b0, item_i.index};
        wdata = item_i.value;
      end
      CMD_START_MST: begin
        sla_d = {item_i.target_address, 1'b0}; merr_d = '0;
        mtl_d = item_i.tx_length; mrl_d = item_i.rx_length;
        if (!busy_q && item_i.status == ST_NO_INFO) begin
          cw = 1'b1;
          cv = C_EN | C_IE | C_STA | (item_i.ctrl_now & C_STO)
             | ((srl_q != '0) ? C_EA : 8'h00);
        end
      end
      CMD_SLV_LISTEN: begin
        serr_d = 1'b0; srl_d = item_i.rx_length; lis_d = 1'b1;
        if (!busy_q && item_i.status == ST_NO_INFO) begin
          cw = 1'b1; cv = C_EA | C_EN | C_IE | (mpend ? C_STA : 8'h00);
        end
      end
      CMD_SLV_RESPOND: begin
        stl_d = item_i.tx_length; cw = 1'b1;
        if (item_i.tx_length != '0) begin
          cv = C_GO | C_EA;
        end else if (mpend) begin
          cv = C_GO | C_STA;
        end else begin
          busy_d = 1'b0; cv = C_GO;
        end
      end
      CMD_READ_BUF: begin
        rbuf = 1'b1; rsel = item_i.buffer_select; rpos = {1'b0, item_i.index};
      end
      default: ;
    endcase

    // Buffer ports; positions beyond the buffer are dropped or read as zero.
    ram_we_o = en_i && we && (int'(wpos) < BUFFER_DEPTH);
    ram_waddr_o = AW'(int'(wsel) * BUFFER_DEPTH + int'(wpos));
    ram_wdata_o = wdata;
    ram_raddr_o = AW'(int'(rsel) * BUFFER_DEPTH + int'(rpos));

    res_o.ctrl_write = cw;
    res_o.ctrl_value = cw ? cv : 8'h00;
    res_o.data_write = dw;
    res_o.data_const = dc;
    res_o.data_from_buf = dbuf;
    res_o.read_from_buf = rbuf;
    res_o.rd_in_range = int'(rpos) < BUFFER_DEPTH;
    res_o.done_events = done;
    res_o.busy = busy_d;
    res_o.master_error = merr_d;
    res_o.slave_error = serr_d;
    res_o.master_count = mri_d;
    res_o.slave_count = sri_d;
    res_o.address_seen = adr_d;
  end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the two-wire master/slave sequencer.
`default_nettype none
module tb;
  import twi_pkg::*;

  localparam int DEPTH = 32;
  localparam int WATCHDOG_LIMIT = 20000;

  // Expected result of one command beat, last field in the lowest bits.
  typedef struct packed {
    logic [7:0] address_seen;
    logic [5:0] slave_count;
    logic [5:0] master_count;
    logic [7:0] read_value;
    logic       slave_error;
    logic [1:0] master_error;
    logic       busy;
    logic [2:0] done_events;
    logic [7:0] data_value;
    logic       data_write;
    logic [7:0] ctrl_value;
    logic       ctrl_write;
  } twi_res_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata;  // command, status, bus_data, ctrl_now, ... rx_length
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [55:0] m_axis_tdata;  // ctrl_write, ctrl_value, ... slave_address_seen

  twi_master_slave_sequencer #(.BUFFER_DEPTH(DEPTH)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // Mirror of the sequencer state.
  logic [7:0] sla_byte_m;
  logic [5:0] mtx_len, mtx_idx, mrx_len, mrx_idx;
  logic [5:0] srx_len, srx_idx, stx_len, stx_idx;
  logic [7:0] addr_seen_m;
  logic       busy_m, listening_m;
  logic [1:0] merr_m;
  logic       serr_m;
  logic [7:0] buf_mem [4*DEPTH];
  bit         buf_written [4*DEPTH];

  in_item_t   cmd_queue[$];
  twi_res_t   expected_results[$];
  bit         hold_until_drained[$];
  bit         no_idle;
  int         mismatches, results_seen, beats_sent, idle_cycles;
  bit         stim_done;
  int         src_gap, sink_gap;

  function automatic logic [5:0] sat_inc(input logic [5:0] x);
    return (x != 6'd63) ? x + 6'd1 : 6'd63;
  endfunction

  function automatic logic [7:0] buf_rd(input logic [1:0] sel, input logic [5:0] pos);
    if (pos >= DEPTH) return 8'h00;
    return buf_mem[sel*DEPTH + pos];
  endfunction

  function automatic void buf_wr(input logic [1:0] sel, input logic [5:0] pos,
                                 input logic [7:0] v);
    if (pos >= DEPTH) return;
    buf_mem[sel*DEPTH + pos] = v;
  endfunction

  function automatic bit master_queued();
    return (mtx_len != 0) || (mrx_len != 0);
  endfunction

  // Computes the sequencer's answer to one beat and advances the mirror state.
  function automatic twi_res_t sequence_beat(input in_item_t it);
    twi_res_t r;
    logic [7:0] cv, dv;
    bit cw, dw, nack_path, sr_nack, st_data, mr_ack;
    logic [2:0] done;
    logic [7:0] rv;
    cw = 0; dw = 0; cv = 0; dv = 0; done = 0; rv = 0;
    nack_path = 0; sr_nack = 0; st_data = 0; mr_ack = 0;
    case (it.command)
      CMD_BUS_EVENT: begin
        case (it.status)
          ST_START, ST_RSTART: begin
            busy_m = 1; mtx_idx = 0; mrx_idx = 0;
            dw = 1; dv = (mtx_len != 0) ? sla_byte_m : (sla_byte_m | 8'h01);
            cw = 1; cv = C_GO | (it.ctrl_now & C_EA);
          end
          ST_MT_SLA_ACK, ST_MT_DAT_ACK: begin
            if (mtx_idx < mtx_len) begin
              dw = 1; dv = buf_rd(BUF_MTX, mtx_idx);
              mtx_idx = sat_inc(mtx_idx);
              cw = 1; cv = C_GO | (it.ctrl_now & C_EA);
            end else begin
              mtx_len = 0;
              if (mrx_len != 0) begin
                cw = 1; cv = C_GO | (it.ctrl_now & C_EA) | C_STA;
              end else nack_path = 1;
            end
          end
          ST_MT_SLA_NACK, ST_MT_DAT_NACK, ST_MR_SLA_NACK: nack_path = 1;
          ST_ARB_LOST: begin
            cw = 1; cv = it.ctrl_now | C_STA; busy_m = 0;
          end
          ST_MR_DAT_ACK: begin
            buf_wr(BUF_MRX, mrx_idx, it.bus_data);
            mrx_idx = sat_inc(mrx_idx);
            mr_ack = 1;
          end
          ST_MR_SLA_ACK: mr_ack = 1;
          ST_MR_DAT_NACK: begin
            buf_wr(BUF_MRX, mrx_idx, it.bus_data);
            mrx_idx = sat_inc(mrx_idx);
            mrx_len = 0; done[0] = 1;
            cw = 1; cv = C_GO | C_STO | ((srx_len != 0) ? C_EA : 8'h00);
            busy_m = 0;
          end
          ST_SR_SLA, ST_SR_SLA_ARB, ST_SR_GCA, ST_SR_GCA_ARB: begin
            cw = 1;
            if (srx_len != 0) begin
              busy_m = 1; addr_seen_m = it.bus_data; cv = C_GO | C_EA; srx_idx = 0;
            end else cv = C_GO;
          end
          ST_SR_DAT_ACK, ST_SR_GDAT_ACK: begin
            if (srx_idx < srx_len) begin
              buf_wr(BUF_SRX, srx_idx, it.bus_data);
              srx_idx = sat_inc(srx_idx);
            end else srx_len = 0;
            if (srx_len != 0) begin
              cw = 1; cv = C_GO | C_EA;
            end else sr_nack = 1;
          end
          ST_SR_DAT_NACK, ST_SR_GDAT_NACK: sr_nack = 1;
          ST_SR_STOP: begin
            cw = 1;
            if (!listening_m || serr_m) begin
              cv = C_GO | (master_queued() ? C_STA : 8'h00); busy_m = 0;
            end else begin
              done[1] = 1; listening_m = 0; srx_len = 0;
              cv = it.ctrl_now & ~(C_INT | C_IE);
            end
          end
          ST_ST_SLA, ST_ST_SLA_ARB: begin
            busy_m = 1; stx_idx = 0; st_data = 1;
          end
          ST_ST_DAT_ACK: st_data = 1;
          ST_ST_DAT_NACK, ST_ST_LAST: begin
            done[2] = 1;
            cw = 1; cv = C_GO | C_EA | (master_queued() ? C_STA : 8'h00);
            busy_m = 0;
          end
          ST_BUS_ERR: begin
            cw = 1; cv = it.ctrl_now | C_STO; busy_m = 0;
            merr_m = 2'd2; serr_m = 1; listening_m = 0; done = 3'b111;
          end
          default: ;
        endcase
        if (nack_path) begin
          if (it.status == ST_MT_SLA_NACK || it.status == ST_MR_SLA_NACK) begin
            merr_m = 2'd1; mtx_len = 0; mrx_len = 0;
          end
          done[0] = 1;
          cw = 1; cv = C_GO | C_STO | ((srx_len != 0) ? C_EA : 8'h00);
          busy_m = 0;
        end
        if (mr_ack) begin
          cw = 1;
          cv = ({1'b0, mrx_idx} + 7'd1 < {1'b0, mrx_len}) ? (C_GO | C_EA) : C_GO;
        end
        if (sr_nack) begin
          cw = 1; cv = it.ctrl_now | C_EA | (master_queued() ? C_STA : 8'h00);
        end
        if (st_data) begin
          dw = 1; cw = 1;
          if (stx_idx < stx_len) begin
            dv = buf_rd(BUF_STX, stx_idx);
            stx_idx = sat_inc(stx_idx);
            if (stx_idx < stx_len) cv = C_GO | C_EA;
            else begin
              stx_len = 0; cv = C_GO;
            end
          end else begin
            dv = 0; cv = C_GO;
          end
        end
      end
      CMD_WRITE_BUF: buf_wr(it.buffer_select, {1'b0, it.index}, it.value);
      CMD_START_MST: begin
        sla_byte_m = {it.target_address, 1'b0};
        merr_m = 2'd0; mtx_len = it.tx_length; mrx_len = it.rx_length;
        if (!busy_m && it.status == ST_NO_INFO) begin
          cw = 1;
          cv = C_EN | C_IE | C_STA | (it.ctrl_now & C_STO) |
               ((srx_len != 0) ? C_EA : 8'h00);
        end
      end
      CMD_SLV_LISTEN: begin
        serr_m = 0; srx_len = it.rx_length; listening_m = 1;
        if (!busy_m && it.status == ST_NO_INFO) begin
          cw = 1; cv = C_EA | C_EN | C_IE | (master_queued() ? C_STA : 8'h00);
        end
      end
      CMD_SLV_RESPOND: begin
        stx_len = it.tx_length; cw = 1;
        if (it.tx_length != 0) cv = C_GO | C_EA;
        else if (master_queued()) cv = C_GO | C_STA;
        else begin
          busy_m = 0; cv = C_GO;
        end
      end
      CMD_READ_BUF: rv = buf_rd(it.buffer_select, {1'b0, it.index});
      default: ;
    endcase
    r.ctrl_write = cw; r.ctrl_value = cw ? cv : 8'h00;
    r.data_write = dw; r.data_value = dw ? dv : 8'h00;
    r.done_events = done; r.busy = busy_m;
    r.master_error = merr_m; r.slave_error = serr_m;
    r.read_value = rv; r.master_count = mrx_idx; r.slave_count = srx_idx;
    r.address_seen = addr_seen_m;
    return r;
  endfunction

  // Builds a beat with random content in every field.
  function automatic in_item_t rand_beat(input cmd_e c);
    in_item_t it;
    it = '0;
    it.command = c;
    it.status = 5'($urandom_range(0, 31));
    it.bus_data = 8'($urandom); it.ctrl_now = 8'($urandom);
    it.buffer_select = 2'($urandom); it.index = 5'($urandom);
    it.value = 8'($urandom);
    it.target_address = 7'($urandom);
    it.tx_length = 6'($urandom_range(0, 32)); it.rx_length = 6'($urandom_range(0, 32));
    return it;
  endfunction

  // Queues a beat; reads of never-written bytes are turned into writes.
  task automatic push_beat(input in_item_t it, input bit drain = 0);
    int slot;
    slot = it.buffer_select*DEPTH + it.index;
    if (it.command == CMD_READ_BUF && it.index < DEPTH && !buf_written[slot])
      it.command = CMD_WRITE_BUF;
    if (it.command == CMD_WRITE_BUF && it.index < DEPTH) buf_written[slot] = 1;
    cmd_queue.push_back(it);
    hold_until_drained.push_back(drain);
  endtask

  task automatic push_event(input logic [4:0] st);
    in_item_t it;
    it = rand_beat(CMD_BUS_EVENT);
    it.status = st;
    push_beat(it);
  endtask

  task automatic fill_buffers();
    in_item_t it;
    for (int s = 0; s < 4; s++)
      for (int i = 0; i < DEPTH; i++) begin
        it = rand_beat(CMD_WRITE_BUF);
        it.buffer_select = 2'(s); it.index = 5'(i);
        push_beat(it);
      end
  endtask

  // Master transfer: start, address, data out, repeated start, data in.
  task automatic master_sequence();
    in_item_t it;
    int ntx, nrx;
    ntx = $urandom_range(0, 5); nrx = $urandom_range(0, 5);
    it = rand_beat(CMD_START_MST);
    it.tx_length = 6'(ntx); it.rx_length = 6'(nrx);
    it.status = ($urandom_range(0, 3) != 0) ? ST_NO_INFO : it.status;
    push_beat(it);
    push_event(ST_START);
    if ($urandom_range(0, 9) == 0) begin
      push_event(($urandom_range(0, 1) != 0) ? ST_MT_SLA_NACK : ST_ARB_LOST);
      return;
    end
    if (ntx != 0) begin
      push_event(ST_MT_SLA_ACK);
      for (int i = 0; i < ntx; i++) push_event(ST_MT_DAT_ACK);
    end
    if (nrx != 0) begin
      push_event(ST_RSTART);
      push_event(ST_MR_SLA_ACK);
      for (int i = 0; i < nrx - 1; i++) push_event(ST_MR_DAT_ACK);
      push_event(ST_MR_DAT_NACK);
    end
  endtask

  // Slave receive and slave transmit exchanges.
  task automatic slave_sequence();
    in_item_t it;
    int n;
    n = $urandom_range(0, 6);
    if ($urandom_range(0, 1) != 0) begin
      it = rand_beat(CMD_SLV_LISTEN);
      it.rx_length = 6'(n);
      it.status = ($urandom_range(0, 1) != 0) ? ST_NO_INFO : it.status;
      push_beat(it);
      push_event(5'($urandom_range(ST_SR_SLA, ST_SR_GCA_ARB)));
      for (int i = 0; i < n + $urandom_range(0, 1); i++)
        push_event(($urandom_range(0, 1) != 0) ? ST_SR_DAT_ACK : ST_SR_GDAT_ACK);
      if ($urandom_range(0, 4) == 0) push_event(ST_SR_DAT_NACK);
      push_event(ST_SR_STOP);
    end else begin
      push_event(($urandom_range(0, 1) != 0) ? ST_ST_SLA : ST_ST_SLA_ARB);
      it = rand_beat(CMD_SLV_RESPOND);
      it.tx_length = 6'(n);
      push_beat(it);
      push_event(ST_ST_SLA);
      for (int i = 0; i < n + $urandom_range(0, 2); i++) push_event(ST_ST_DAT_ACK);
      push_event(($urandom_range(0, 1) != 0) ? ST_ST_LAST : ST_ST_DAT_NACK);
    end
  endtask

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // Stimulus plan.
  initial begin
    in_item_t it;
    for (int i = 0; i < 4*DEPTH; i++) begin
      buf_mem[i] = 0; buf_written[i] = 0;
    end
    // Directed: field extremes, every command and the named special cases.
    it = '0; it.command = CMD_WRITE_BUF; it.index = 5'd31; it.value = 8'hFF;
    it.buffer_select = BUF_STX; push_beat(it);
    it = '1; it.command = CMD_WRITE_BUF; push_beat(it);
    it = '0; it.command = CMD_READ_BUF; it.index = 5'd31; it.buffer_select = BUF_STX;
    push_beat(it);
    it = '1; it.command = CMD_RSVD6; push_beat(it);
    it = '1; it.command = CMD_RSVD7; push_beat(it);
    it = '1; it.command = CMD_BUS_EVENT; it.status = ST_NO_INFO; push_beat(it);
    it = '0; it.command = CMD_BUS_EVENT; it.status = 5'h1A; push_beat(it);
    it = '1; it.command = CMD_START_MST; it.tx_length = 6'd32; it.rx_length = 6'd32;
    it.status = ST_NO_INFO; push_beat(it);
    it = '1; it.command = CMD_SLV_LISTEN; it.rx_length = 6'd32; it.status = ST_NO_INFO;
    push_beat(it);
    push_event(ST_START);
    push_event(ST_ARB_LOST);
    push_event(ST_ST_SLA);
    push_event(ST_ST_DAT_ACK);
    it = '1; it.command = CMD_SLV_RESPOND; it.tx_length = 6'd0; push_beat(it);
    push_event(ST_BUS_ERR);
    it = '0; it.command = CMD_START_MST; it.tx_length = 6'd0; it.rx_length = 6'd0;
    it.status = ST_NO_INFO; push_beat(it, 1);
    // Index saturation: long reads past the buffer end.
    it = '0; it.command = CMD_START_MST; it.rx_length = 6'd63; it.status = ST_NO_INFO;
    push_beat(it);
    push_event(ST_START);
    for (int i = 0; i < 70; i++) push_event(ST_MR_DAT_ACK);
    push_event(ST_MR_DAT_NACK);
    fill_buffers();
    // Random part: mostly well-formed exchanges, some noise.
    while (cmd_queue.size() < 750) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: master_sequence();
        4, 5, 6, 7: slave_sequence();
        8: push_beat(rand_beat(cmd_e'($urandom_range(0, 7))));
        default: push_event(5'($urandom_range(0, 31)));
      endcase
      if ($urandom_range(0, 40) == 0) hold_until_drained[$] = 1;
    end
  end

  // Reset.
  initial begin
    rst_ni = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
  end

  // Driver: offers queued beats with random gaps.
  initial begin
    s_axis_tvalid = 0; s_axis_tdata = '0; m_axis_tready = 0;
    src_gap = 0; sink_gap = 0; no_idle = 0; stim_done = 0;
    mismatches = 0; results_seen = 0; beats_sent = 0; idle_cycles = 0;
    sla_byte_m = 0; mtx_len = 0; mtx_idx = 0; mrx_len = 0; mrx_idx = 0;
    srx_len = 0; srx_idx = 0; stx_len = 0; stx_idx = 0; addr_seen_m = 0;
    busy_m = 0; listening_m = 0; merr_m = 0; serr_m = 0;
  end

  bit waiting_drain;
  initial waiting_drain = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(sequence_beat(in_item_t'(s_axis_tdata[57:0])));
        beats_sent <= beats_sent + 1;
        waiting_drain = hold_until_drained.pop_front();
        void'(cmd_queue.pop_front());
      end
      if (beats_sent > 600) no_idle <= 1;
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (waiting_drain && expected_results.size() != 0) begin
          s_axis_tvalid <= 0;
        end else if (cmd_queue.size() == 0) begin
          waiting_drain = 0;
          s_axis_tvalid <= 0;
          stim_done <= 1;
        end else if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 0;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
          src_gap <= $urandom_range(0, 6);
          s_axis_tvalid <= 0;
        end else begin
          waiting_drain = 0;
          s_axis_tvalid <= 1;
          s_axis_tdata <= {6'd0, cmd_queue[0]};
        end
      end
    end
  end

  // Monitor: result sink with random stalls, field-by-field compare.
  always @(posedge clk_i) begin
    twi_res_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[52:0];
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result beat %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("result %0d mismatch: expected %h, got %h",
                       results_seen, want, got);
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_axis_tready <= 0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        sink_gap <= $urandom_range(0, 6);
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // End of run.
  initial begin
    int tail;
    tail = 0;
    @(posedge rst_ni);
    while (!(stim_done && expected_results.size() == 0 && tail > 8) &&
           idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (stim_done && expected_results.size() == 0) tail++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("status: fail");
      $finish;
    end else begin
      $display("ran %0d command beats (master, slave, buffer and bus-error traffic),",
               beats_sent);
      $display("checked %0d result beats, %0d mismatches", results_seen, mismatches);
      if (mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
    end
  end

endmodule
`default_nettype wire
